// File: rtl/core/nlzg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nlzg_pkg;

	localparam int HIST_DEPTH = 256;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_FLAG  = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;
	localparam logic [1:0] OP_PULL  = 2'd3;

	localparam logic [12:0] END_LIMIT  = 13'd3000;
	localparam logic [12:0] VALUE_MAX  = 13'd8191;
	localparam logic [12:0] WEIGHT_MAX = 13'd4096;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_FLAG,
		CMD_DATA,
		CMD_PULL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] operand;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_NIB       = 3'd0,
		ST_NEED_FLAG = 3'd1,
		ST_NEED_DATA = 3'd2,
		ST_END       = 3'd3,
		ST_OK        = 3'd4,
		ST_ERR       = 3'd5
	} status_t;

endpackage

`default_nettype wire

// File: rtl/core/nlzg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module nlzg_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	input  wire  [1:0]          operation,
	input  wire  [31:0]         flag_word,
	input  wire  [7:0]          data_byte,
	output logic                head_valid,
	output nlzg_pkg::cmd_t      head,
	input  wire                 pop
);

	nlzg_pkg::cmd_t                 q_mem [nlzg_pkg::QDEPTH];
	logic [nlzg_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [nlzg_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [nlzg_pkg::QPTR_W:0]      count_q;
	nlzg_pkg::cmd_t                 cmd;
	logic                           push;

	// classify the incoming transaction
	always_comb begin
		cmd.kind    = nlzg_pkg::CMD_PULL;
		cmd.operand = '0;
		unique case (operation)
			nlzg_pkg::OP_START: begin
				cmd.kind = nlzg_pkg::CMD_START;
			end
			nlzg_pkg::OP_FLAG: begin
				cmd.kind    = nlzg_pkg::CMD_FLAG;
				cmd.operand = flag_word;
			end
			nlzg_pkg::OP_DATA: begin
				cmd.kind    = nlzg_pkg::CMD_DATA;
				cmd.operand = {24'd0, data_byte};
			end
			default: begin
				cmd.kind = nlzg_pkg::CMD_PULL;
			end
		endcase
	end

	assign item_stall = (count_q == (nlzg_pkg::QPTR_W+1)'(nlzg_pkg::QDEPTH));
	assign push       = item_valid && !item_stall;
	assign head_valid = (count_q != '0);
	assign head       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/nlzg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module nlzg_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  wire nlzg_pkg::cmd_t head,
	output logic                pop,
	output logic                result_valid,
	input  wire                 result_stall,
	output logic [2:0]          status,
	output logic [3:0]          nibble,
	output logic                from_copy
);

	localparam int AW     = nlzg_pkg::HIST_AW;
	localparam int DIST_W = 9;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FIRST,
		PH_TOKEN,
		PH_DIST,
		PH_GSTOP,
		PH_GDATA,
		PH_COPY,
		PH_END
	} phase_t;

	typedef enum logic {
		E_RUN,
		E_RD
	} eng_t;

	// stream state
	logic [31:0]  flag_bits_q,    flag_bits_d;
	logic [5:0]   flag_left_q,    flag_left_d;
	logic [7:0]   held_byte_q,    held_byte_d;
	logic         held_valid_q,   held_valid_d;
	logic         low_next_q,     low_next_d;
	phase_t       phase_q,        phase_d;
	logic [7:0]   dist_q,         dist_d;
	logic         dist_taken_q,   dist_taken_d;
	logic [12:0]  len_value_q,    len_value_d;
	logic [12:0]  len_weight_q,   len_weight_d;
	logic [11:0]  copy_rem_q,     copy_rem_d;
	logic [AW-1:0] wp_q,          wp_d;
	eng_t         eng_q,          eng_d;

	// output register
	logic         result_valid_q;
	nlzg_pkg::status_t status_q;
	logic [3:0]   nibble_q;
	logic         from_copy_q;

	// history
	logic [3:0]   hist_mem [nlzg_pkg::HIST_DEPTH];
	logic [nlzg_pkg::HIST_DEPTH-1:0] hist_vld_q;
	logic [3:0]   rd_nib_q;
	logic         rd_vld_q;
	logic         rd_en;
	logic [AW-1:0] rd_idx;
	logic         wr_en;
	logic [3:0]   wr_nib;

	// step results
	logic         out_free;
	logic         emit;
	nlzg_pkg::status_t res_status;
	logic [3:0]   res_nib;
	logic         res_copy;

	logic [4:0]   flag_idx;
	logic         flag_top;
	logic [3:0]   cur_nib;
	logic [13:0]  gsum;
	logic [12:0]  gsat;
	logic [12:0]  wdbl;
	logic         active;
	logic [DIST_W-1:0] dist_ext;
	logic [AW:0]  idx_w;
	logic [3:0]   copy_nib;

	assign out_free = !result_valid_q || !result_stall;
	assign flag_idx = 5'(flag_left_q - 6'd1);
	assign flag_top = flag_bits_q[flag_idx];
	assign cur_nib  = low_next_q ? held_byte_q[3:0] : held_byte_q[7:4];
	assign gsum     = {1'b0, len_value_q} + {1'b0, len_weight_q};
	assign gsat     = (gsum > {1'b0, nlzg_pkg::VALUE_MAX}) ? nlzg_pkg::VALUE_MAX : gsum[12:0];
	assign wdbl     = (len_weight_q >= nlzg_pkg::WEIGHT_MAX) ? nlzg_pkg::WEIGHT_MAX
	                                                         : {len_weight_q[11:0], 1'b0};
	assign active   = (phase_q != PH_IDLE) && (phase_q != PH_END);
	assign dist_ext = (dist_q == 8'd0) ? DIST_W'(256) : {1'b0, dist_q};
	assign idx_w    = {1'b0, wp_q} - (AW+1)'(dist_ext);
	assign rd_idx   = idx_w[AW-1:0];
	assign copy_nib = rd_vld_q ? rd_nib_q : 4'd0;

	always_comb begin
		flag_bits_d  = flag_bits_q;
		flag_left_d  = flag_left_q;
		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		low_next_d   = low_next_q;
		phase_d      = phase_q;
		dist_d       = dist_q;
		dist_taken_d = dist_taken_q;
		len_value_d  = len_value_q;
		len_weight_d = len_weight_q;
		copy_rem_d   = copy_rem_q;
		wp_d         = wp_q;
		eng_d        = eng_q;
		pop          = 1'b0;
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		wr_nib       = 4'd0;
		emit         = 1'b0;
		res_status   = nlzg_pkg::ST_NIB;
		res_nib      = 4'd0;
		res_copy     = 1'b0;

		if (head_valid && out_free) begin
			unique case (eng_q)
				E_RD: begin
					wr_en      = 1'b1;
					wr_nib     = copy_nib;
					wp_d       = wp_q + 1'b1;
					copy_rem_d = copy_rem_q - 12'd1;
					if (copy_rem_q == 12'd1) begin
						flag_left_d = flag_left_q - 6'd1;
						phase_d     = PH_TOKEN;
					end
					emit     = 1'b1;
					res_nib  = copy_nib;
					res_copy = 1'b1;
					pop      = 1'b1;
					eng_d    = E_RUN;
				end
				default: begin
					unique case (head.kind)
						nlzg_pkg::CMD_START: begin
							flag_bits_d  = '0;
							flag_left_d  = '0;
							held_byte_d  = '0;
							held_valid_d = 1'b0;
							low_next_d   = 1'b0;
							dist_d       = '0;
							dist_taken_d = 1'b0;
							len_value_d  = '0;
							len_weight_d = 13'd1;
							copy_rem_d   = '0;
							phase_d      = PH_FIRST;
							emit         = 1'b1;
							res_status   = nlzg_pkg::ST_OK;
							pop          = 1'b1;
						end
						nlzg_pkg::CMD_FLAG: begin
							emit = 1'b1;
							pop  = 1'b1;
							if (!active || flag_left_q != 6'd0) begin
								res_status = nlzg_pkg::ST_ERR;
							end else begin
								flag_bits_d = head.operand;
								flag_left_d = 6'd32;
								res_status  = nlzg_pkg::ST_OK;
							end
						end
						nlzg_pkg::CMD_DATA: begin
							emit = 1'b1;
							pop  = 1'b1;
							if (!active || held_valid_q) begin
								res_status = nlzg_pkg::ST_ERR;
							end else begin
								held_byte_d  = head.operand[7:0];
								held_valid_d = 1'b1;
								low_next_d   = 1'b0;
								res_status   = nlzg_pkg::ST_OK;
							end
						end
						default: begin
							unique case (phase_q)
								PH_IDLE: begin
									emit       = 1'b1;
									pop        = 1'b1;
									res_status = nlzg_pkg::ST_ERR;
								end
								PH_FIRST: begin
									emit = 1'b1;
									pop  = 1'b1;
									if (!held_valid_q) begin
										res_status = nlzg_pkg::ST_NEED_DATA;
									end else begin
										low_next_d   = !low_next_q;
										held_valid_d = !low_next_q;
										wr_en        = 1'b1;
										wr_nib       = cur_nib;
										wp_d         = wp_q + 1'b1;
										phase_d      = PH_TOKEN;
										res_nib      = cur_nib;
									end
								end
								PH_TOKEN: begin
									if (flag_left_q == 6'd0) begin
										emit       = 1'b1;
										pop        = 1'b1;
										res_status = nlzg_pkg::ST_NEED_FLAG;
									end else if (flag_top) begin
										emit = 1'b1;
										pop  = 1'b1;
										if (!held_valid_q) begin
											res_status = nlzg_pkg::ST_NEED_DATA;
										end else begin
											flag_left_d  = flag_left_q - 6'd1;
											low_next_d   = !low_next_q;
											held_valid_d = !low_next_q;
											wr_en        = 1'b1;
											wr_nib       = cur_nib;
											wp_d         = wp_q + 1'b1;
											res_nib      = cur_nib;
										end
									end else begin
										flag_left_d  = flag_left_q - 6'd1;
										dist_d       = '0;
										dist_taken_d = 1'b0;
										phase_d      = PH_DIST;
									end
								end
								PH_DIST: begin
									if (!held_valid_q) begin
										emit       = 1'b1;
										pop        = 1'b1;
										res_status = nlzg_pkg::ST_NEED_DATA;
									end else begin
										dist_d       = {dist_q[3:0], cur_nib};
										low_next_d   = !low_next_q;
										held_valid_d = !low_next_q;
										if (dist_taken_q) begin
											len_value_d  = '0;
											len_weight_d = 13'd1;
											phase_d      = PH_GSTOP;
										end else begin
											dist_taken_d = 1'b1;
										end
									end
								end
								PH_GSTOP: begin
									if (flag_left_q == 6'd0) begin
										emit       = 1'b1;
										pop        = 1'b1;
										res_status = nlzg_pkg::ST_NEED_FLAG;
									end else if (flag_top) begin
										// closing bit stays until the copy is done
										len_value_d = gsat;
										if (gsat >= nlzg_pkg::END_LIMIT) begin
											phase_d    = PH_END;
											emit       = 1'b1;
											pop        = 1'b1;
											res_status = nlzg_pkg::ST_END;
										end else begin
											copy_rem_d = gsat[11:0] + 12'd2;
											phase_d    = PH_COPY;
										end
									end else begin
										flag_left_d = flag_left_q - 6'd1;
										phase_d     = PH_GDATA;
									end
								end
								PH_GDATA: begin
									if (flag_left_q == 6'd0) begin
										emit       = 1'b1;
										pop        = 1'b1;
										res_status = nlzg_pkg::ST_NEED_FLAG;
									end else begin
										flag_left_d = flag_left_q - 6'd1;
										if (flag_top) begin
											len_value_d = gsat;
										end
										len_weight_d = wdbl;
										phase_d      = PH_GSTOP;
									end
								end
								PH_COPY: begin
									rd_en = 1'b1;
									eng_d = E_RD;
								end
								default: begin
									emit       = 1'b1;
									pop        = 1'b1;
									res_status = nlzg_pkg::ST_END;
								end
							endcase
						end
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_bits_q    <= '0;
			flag_left_q    <= '0;
			held_byte_q    <= '0;
			held_valid_q   <= 1'b0;
			low_next_q     <= 1'b0;
			phase_q        <= PH_IDLE;
			dist_q         <= '0;
			dist_taken_q   <= 1'b0;
			len_value_q    <= '0;
			len_weight_q   <= 13'd1;
			copy_rem_q     <= '0;
			wp_q           <= '0;
			eng_q          <= E_RUN;
			result_valid_q <= 1'b0;
			status_q       <= nlzg_pkg::ST_NIB;
			nibble_q       <= '0;
			from_copy_q    <= 1'b0;
		end else begin
			flag_bits_q  <= flag_bits_d;
			flag_left_q  <= flag_left_d;
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			low_next_q   <= low_next_d;
			phase_q      <= phase_d;
			dist_q       <= dist_d;
			dist_taken_q <= dist_taken_d;
			len_value_q  <= len_value_d;
			len_weight_q <= len_weight_d;
			copy_rem_q   <= copy_rem_d;
			wp_q         <= wp_d;
			eng_q        <= eng_d;
			if (emit) begin
				result_valid_q <= 1'b1;
				status_q       <= res_status;
				nibble_q       <= res_nib;
				from_copy_q    <= res_copy;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
		end else if (wr_en) begin
			hist_vld_q[wp_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wp_q] <= wr_nib;
		end
		if (rd_en) begin
			rd_nib_q <= hist_mem[rd_idx];
			rd_vld_q <= hist_vld_q[rd_idx];
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign nibble       = nibble_q;
	assign from_copy    = from_copy_q;

endmodule

`default_nettype wire

// File: rtl/core/nibble_lz_gamma_decoder.sv
// Flow: an accepted transaction enters the queue, and a start or load is answered
// through the registered result outputs. A pull takes one decode step per token, distance
// nibble or gamma bit, plus a history read for a copied nibble, so the first nibble of
// a match takes more steps than a literal. The decode sequencer works on one transaction
// at a time, and a 2-entry queue buffers input meanwhile.
// Reset: arst_n clears all control state; history reads as zero until written.
`timescale 1ns / 1ps
`default_nettype none

module nibble_lz_gamma_decoder (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         item_valid,
	output logic        item_stall,
	input  wire  [1:0]  operation,
	input  wire  [31:0] flag_word,
	input  wire  [7:0]  data_byte,
	output logic        result_valid,
	input  wire         result_stall,
	output logic [2:0]  status,
	output logic [3:0]  nibble,
	output logic        from_copy
);

	logic           head_valid;
	nlzg_pkg::cmd_t head;
	logic           pop;

	nlzg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.flag_word  (flag_word),
		.data_byte  (data_byte),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	nlzg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.nibble       (nibble),
		.from_copy    (from_copy)
	);

endmodule

`default_nettype wire

// File: dv/nlzg_stream_checker.sv
`timescale 1ns / 1ps

module nlzg_stream_checker
	import nlzg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] flag_word,
	input  logic [7:0]  data_byte,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [2:0]  status,
	input  logic [3:0]  nibble,
	input  logic        from_copy,
	output int          fail_count,
	output int          pending,
	output int          copy_nibbles,
	output int          stream_ends
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FIRST,
		PH_TOKEN,
		PH_DIST,
		PH_GSTOP,
		PH_GDATA,
		PH_COPY,
		PH_END
	} phase_t;

	typedef struct packed {
		status_t    st;
		logic [3:0] nib;
		logic       cp;
	} answer_t;

	answer_t pending_answers[$];

	logic [31:0]         flags;
	logic [5:0]          flags_left;
	logic [7:0]          held_byte;
	logic                byte_valid;
	logic                low_next;
	phase_t              phase;
	logic [7:0]          match_dist;
	logic [1:0]          dist_taken;
	logic [12:0]         len_val;
	logic [12:0]         len_wt;
	logic [11:0]         copy_left;
	logic [3:0]          hist [HIST_DEPTH];
	logic [HIST_AW-1:0]  wr_ptr;

	function automatic void clear_stream();
		flags      = '0;
		flags_left = '0;
		held_byte  = '0;
		byte_valid = 1'b0;
		low_next   = 1'b0;
		match_dist = '0;
		dist_taken = '0;
		len_val    = '0;
		len_wt     = 13'd1;
		copy_left  = '0;
	endfunction

	function automatic logic [3:0] next_nibble();
		logic [3:0] n;
		if (low_next) begin
			n = held_byte[3:0];
			byte_valid = 1'b0;
			low_next = 1'b0;
		end else begin
			n = held_byte[7:4];
			low_next = 1'b1;
		end
		return n;
	endfunction

	function automatic logic peek_flag();
		logic [5:0] i;
		i = flags_left - 6'd1;
		return flags[i[4:0]];
	endfunction

	function automatic logic pop_flag();
		flags_left = flags_left - 6'd1;
		return flags[flags_left[4:0]];
	endfunction

	function automatic void remember(logic [3:0] n);
		hist[wr_ptr] = n;
		wr_ptr = wr_ptr + 1'b1;
	endfunction

	function automatic logic [12:0] sat_add(logic [12:0] a, logic [12:0] b);
		logic [13:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, VALUE_MAX}) ? VALUE_MAX : s[12:0];
	endfunction

	function automatic answer_t decode_item(logic [1:0] op, logic [31:0] fw, logic [7:0] db);
		answer_t            a;
		logic               active;
		logic               done;
		logic [3:0]         n;
		logic [12:0]        sum;
		logic [HIST_AW-1:0] idx;
		a = '{st: ST_OK, nib: 4'd0, cp: 1'b0};
		active = (phase != PH_IDLE) && (phase != PH_END);
		case (op)
			OP_START: begin
				clear_stream();
				phase = PH_FIRST;
			end
			OP_FLAG: begin
				if (!active || flags_left != 0) begin
					a.st = ST_ERR;
				end else begin
					flags = fw;
					flags_left = 6'd32;
				end
			end
			OP_DATA: begin
				if (!active || byte_valid) begin
					a.st = ST_ERR;
				end else begin
					held_byte = db;
					byte_valid = 1'b1;
					low_next = 1'b0;
				end
			end
			default: begin
				if (phase == PH_IDLE) begin
					a.st = ST_ERR;
				end else begin
					done = 1'b0;
					while (!done) begin
						case (phase)
							PH_FIRST: begin
								done = 1'b1;
								if (!byte_valid) begin
									a.st = ST_NEED_DATA;
								end else begin
									n = next_nibble();
									remember(n);
									phase = PH_TOKEN;
									a.st = ST_NIB;
									a.nib = n;
								end
							end
							PH_TOKEN: begin
								if (flags_left == 0) begin
									a.st = ST_NEED_FLAG;
									done = 1'b1;
								end else if (peek_flag()) begin
									done = 1'b1;
									if (!byte_valid) begin
										a.st = ST_NEED_DATA;
									end else begin
										void'(pop_flag());
										n = next_nibble();
										remember(n);
										a.st = ST_NIB;
										a.nib = n;
									end
								end else begin
									void'(pop_flag());
									match_dist = '0;
									dist_taken = '0;
									phase = PH_DIST;
								end
							end
							PH_DIST: begin
								if (!byte_valid) begin
									a.st = ST_NEED_DATA;
									done = 1'b1;
								end else begin
									match_dist = {match_dist[3:0], next_nibble()};
									dist_taken = dist_taken + 2'd1;
									if (dist_taken >= 2'd2) begin
										len_val = '0;
										len_wt = 13'd1;
										phase = PH_GSTOP;
									end
								end
							end
							PH_GSTOP: begin
								if (flags_left == 0) begin
									a.st = ST_NEED_FLAG;
									done = 1'b1;
								end else if (peek_flag()) begin
									// closing bit stays until the copy is done
									sum = sat_add(len_val, len_wt);
									len_val = sum;
									if (sum >= END_LIMIT) begin
										phase = PH_END;
										a.st = ST_END;
										done = 1'b1;
									end else begin
										copy_left = 12'(sum + 13'd2);
										phase = PH_COPY;
									end
								end else begin
									void'(pop_flag());
									phase = PH_GDATA;
								end
							end
							PH_GDATA: begin
								if (flags_left == 0) begin
									a.st = ST_NEED_FLAG;
									done = 1'b1;
								end else begin
									if (pop_flag())
										len_val = sat_add(len_val, len_wt);
									len_wt = (len_wt >= WEIGHT_MAX) ? WEIGHT_MAX : (len_wt << 1);
									phase = PH_GSTOP;
								end
							end
							PH_COPY: begin
								// distance zero wraps to the full ring
								idx = wr_ptr - match_dist;
								n = hist[idx];
								remember(n);
								copy_left = copy_left - 12'd1;
								if (copy_left == 0) begin
									void'(pop_flag());
									phase = PH_TOKEN;
								end
								a.st = ST_NIB;
								a.nib = n;
								a.cp = 1'b1;
								done = 1'b1;
							end
							default: begin
								a.st = ST_END;
								done = 1'b1;
							end
						endcase
					end
				end
			end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		int      errs;
		if (!arst_n) begin
			clear_stream();
			phase = PH_IDLE;
			wr_ptr = '0;
			for (int k = 0; k < HIST_DEPTH; k++)
				hist[k] = '0;
			pending_answers.delete();
			fail_count <= 0;
			pending <= 0;
			copy_nibbles <= 0;
			stream_ends <= 0;
		end else begin
			errs = 0;
			if (item_valid && !item_stall)
				pending_answers.push_back(decode_item(operation, flag_word, data_byte));
			if (result_valid && !result_stall) begin
				if (pending_answers.size() == 0) begin
					$error("unexpected result: status %0d nibble %0h from_copy %0b",
						status, nibble, from_copy);
					errs++;
				end else begin
					exp_a = pending_answers.pop_front();
					if (status !== exp_a.st) begin
						$error("status: expected %0d, got %0d", exp_a.st, status);
						errs++;
					end
					if (nibble !== exp_a.nib) begin
						$error("nibble: expected %0h, got %0h", exp_a.nib, nibble);
						errs++;
					end
					if (from_copy !== exp_a.cp) begin
						$error("from_copy: expected %0b, got %0b", exp_a.cp, from_copy);
						errs++;
					end
					if (exp_a.cp)
						copy_nibbles <= copy_nibbles + 1;
					if (exp_a.st == ST_END)
						stream_ends <= stream_ends + 1;
				end
			end
			fail_count <= fail_count + errs;
			pending <= pending_answers.size();
		end
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import nlzg_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_OUTSTANDING = 6;
	localparam int ITEMS_PER_MIX = 325;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  operation = OP_PULL;
	logic [31:0] flag_word = '0;
	logic [7:0]  data_byte = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  status;
	logic [3:0]  nibble;
	logic        from_copy;

	int fail_count;
	int pending;
	int copy_nibbles;
	int stream_ends;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int idle_tab[4]  = '{0, 75, 0, 28};
	int stall_tab[4] = '{0, 0, 75, 28};

	int sent_cnt = 0;
	int recv_cnt = 0;
	int start_idx = -1;
	int flag_idx = -1;
	int data_idx = -1;
	int need_flag_at = -1;
	int need_data_at = -1;
	int end_at = -1;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	nibble_lz_gamma_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.flag_word    (flag_word),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.nibble       (nibble),
		.from_copy    (from_copy)
	);

	nlzg_stream_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.flag_word    (flag_word),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.nibble       (nibble),
		.from_copy    (from_copy),
		.fail_count   (fail_count),
		.pending      (pending),
		.copy_nibbles (copy_nibbles),
		.stream_ends  (stream_ends)
	);

	always @(posedge clk)
		result_stall <= ($urandom_range(0, 99) < stall_pct);

	// track what the decoder last asked for, per result index
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			recv_cnt <= recv_cnt + 1;
			case (status)
				ST_NEED_FLAG: need_flag_at <= recv_cnt;
				ST_NEED_DATA: need_data_at <= recv_cnt;
				ST_END:       end_at <= recv_cnt;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[nibble_lz_gamma_decoder] ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [31:0] fw, input logic [7:0] db);
		while ((sent_cnt - recv_cnt >= MAX_OUTSTANDING) ||
		       ($urandom_range(0, 99) < send_idle_pct)) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		flag_word <= fw;
		data_byte <= db;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		case (op)
			OP_START: start_idx = sent_cnt;
			OP_FLAG:  flag_idx = sent_cnt;
			OP_DATA:  data_idx = sent_cnt;
			default: ;
		endcase
		sent_cnt++;
	endtask

	function automatic logic [31:0] gen_flags();
		int m;
		m = $urandom_range(0, 9);
		case (m)
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return $urandom | $urandom;
			7:          return $urandom | $urandom | $urandom;
			8: begin
				case ($urandom_range(0, 3))
					0:       return 32'h0000_0000;
					1:       return 32'hffff_ffff;
					2:       return 32'h5555_5555;
					default: return 32'haaaa_aaaa;
				endcase
			end
			default:    return $urandom & $urandom;
		endcase
	endfunction

	initial begin
		int r;
		int flag_base;
		int data_base;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle decoder, then a short stream: literal, distance-zero match, saturated end
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_FLAG, 32'hffff_ffff, 8'h00);
		send_item(OP_DATA, 32'h0, 8'hff);
		send_item(OP_START, 32'h0, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_DATA, 32'h0, 8'hf0);
		send_item(OP_DATA, 32'h0, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_FLAG, 32'ha555_5558, 8'h00);
		send_item(OP_FLAG, 32'h0000_0000, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_DATA, 32'h0, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_DATA, 32'h0, 8'hff);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_PULL, 32'h0, 8'h00);
		send_item(OP_FLAG, 32'h1234_5678, 8'h00);
		send_item(OP_DATA, 32'h0, 8'h5a);
		send_item(OP_START, 32'h0, 8'h00);

		for (int mix = 0; mix < 4; mix++) begin
			send_idle_pct = idle_tab[mix];
			stall_pct <= stall_tab[mix];
			for (int i = 0; i < ITEMS_PER_MIX; i++) begin
				r = $urandom_range(0, 99);
				flag_base = (flag_idx > start_idx) ? flag_idx : start_idx;
				data_base = (data_idx > start_idx) ? data_idx : start_idx;
				if (r < 4)
					send_item(2'($urandom_range(0, 3)), $urandom, 8'($urandom_range(0, 255)));
				else if (r < 5 || end_at > start_idx)
					send_item(OP_START, $urandom, 8'($urandom_range(0, 255)));
				else if (need_flag_at > flag_base)
					send_item(OP_FLAG, gen_flags(), 8'($urandom_range(0, 255)));
				else if (need_data_at > data_base)
					send_item(OP_DATA, $urandom, 8'($urandom_range(0, 255)));
				else
					send_item(OP_PULL, $urandom, 8'($urandom_range(0, 255)));
			end
		end
		item_valid <= 1'b0;

		while (recv_cnt != sent_cnt)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		$display("Covered %0d transactions over four idle/stall mixes", sent_cnt);
		$display("including %0d copied nibbles and %0d stream ends", copy_nibbles, stream_ends);
		if (fail_count == 0 && pending == 0)
			$display("[nibble_lz_gamma_decoder] OK");
		else
			$display("[nibble_lz_gamma_decoder] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/nlzg_pkg.sv
rtl/core/nlzg_front.sv
rtl/core/nlzg_back.sv
rtl/core/nibble_lz_gamma_decoder.sv
dv/nlzg_stream_checker.sv
dv/tb_top.sv
